[sv/assert_macros.svh]
// shared assertion macros for the allocator checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define BFA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("allocator check failed");

// property checked at every clock edge, reset included
`define BFA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("allocator check failed");

`endif

[sv/bfa_pkg.sv]
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int WORD_W = 32;
    typedef logic [WORD_W-1:0] t_word;

    // header word layout
    localparam t_word HDR_ALLOC     = 32'h1;
    localparam t_word HDR_PREV      = 32'h2;
    localparam t_word SIZE_LOW_MASK = 32'h7;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // heap layout after reset
    localparam int INIT_CHUNK   = 1 << 12;
    localparam int PAYLOAD_BASE = 16;
    localparam int MIN_BLOCK    = 16;
    localparam int SPLIT_MIN    = 16;
    localparam int CHUNK_W      = 17;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(INIT_CHUNK);

    // configuration register indexes
    localparam logic REG_GROW_CHUNK = 1'b0;

    function automatic t_word pack(input t_word s, input logic a, input logic pa);
        t_word w;
        w = (s & ~SIZE_LOW_MASK) | (pa ? HDR_PREV : '0) | (a ? HDR_ALLOC : '0);
        return w;
    endfunction

endpackage

[sv/bfa_ram.sv]
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/best_fit_free_list_allocator_unit.sv]
`timescale 1ns / 1ps

// Best-fit heap allocator with an explicit doubly linked free list. The heap is a
// word memory of HEAP_BYTES bytes; every block carries a header word (size in bits
// 31..3, previous-allocated bit 1, allocated bit 0), free blocks also a footer and
// pred/succ links in their first two payload words. An allocate item (mode 0)
// returns the payload offset of a block of 8*ceil((bytes+4)/8) bytes (16 minimum),
// chosen as the exact fit or else the smallest fit (the later one on a tie), split
// when 16 bytes or more are left; if nothing fits the heap grows by the larger of
// the request and grow_chunk_bytes rounded up to 8, or the item fails with address
// 0 and ok 0 once HEAP_BYTES would be passed. A free item (mode 1) is checked by a
// walk over the blocks, coalesced with free neighbors and pushed at the list head;
// address 0 is a no-op with ok 1, a block that is not live gives ok 0.
// Operation: after reset a clearing pass writes the start image into the heap
// memory, during which no item is accepted. All work runs through one sequencer
// over a single heap memory with one read and one write port and a registered
// read. One item is in work at a time.
// Configuration: grow_chunk_bytes at byte address 0 of the APB port, reset 4096.
module best_fit_free_list_allocator_unit #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [16:0] i_request_bytes,
    input  logic [15:0] i_block_addr,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_result_addr,
    output logic        o_ok,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // geometry
    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int WA         = $clog2(HEAP_WORDS);
    // byte address width with headroom for break plus growth
    localparam int AW         = (($clog2(HEAP_BYTES) > 18) ? $clog2(HEAP_BYTES) : 18) + 2;
    localparam int WALK_LIMIT = HEAP_BYTES / 16 + 2;
    localparam int CW         = $clog2(WALK_LIMIT + 1);

    localparam logic [AW-1:0] HEAP_LIM = AW'(HEAP_BYTES);
    localparam logic [CW-1:0] WALK_MAX = CW'(WALK_LIMIT);
    localparam logic [AW-1:0] BASE     = AW'(bfa_pkg::PAYLOAD_BASE);
    localparam logic [AW-1:0] BRK_INIT = AW'(bfa_pkg::PAYLOAD_BASE + bfa_pkg::INIT_CHUNK);
    localparam logic [AW-1:0] A4       = AW'(4);
    localparam logic [AW-1:0] A8       = AW'(8);

    // start image of the heap
    localparam logic [WA-1:0] IDX_PRO = WA'(1);
    localparam logic [WA-1:0] IDX_HDR = WA'(3);
    localparam logic [WA-1:0] IDX_FTR =
        WA'((bfa_pkg::PAYLOAD_BASE + bfa_pkg::INIT_CHUNK - 8) / 4);
    localparam logic [WA-1:0] IDX_EPI =
        WA'((bfa_pkg::PAYLOAD_BASE + bfa_pkg::INIT_CHUNK - 4) / 4);
    localparam logic [WA-1:0] IDX_LAST = WA'(HEAP_WORDS - 1);
    localparam bfa_pkg::t_word PRO_WORD = bfa_pkg::pack(32'd8, 1'b1, 1'b0);
    localparam bfa_pkg::t_word CHK_WORD =
        bfa_pkg::pack(32'(bfa_pkg::INIT_CHUNK), 1'b0, 1'b1);
    localparam bfa_pkg::t_word EPI_WORD = bfa_pkg::pack(32'd0, 1'b1, 1'b0);

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE,
        S_BF_CHK, S_BF_SZ, S_BF_NX, S_BF_END,
        S_G_CHK, S_G_PA, S_G_W1, S_G_W2,
        S_M0, S_M1, S_M2, S_M_PA1, S_M_PA2, S_M_PV, S_M_PV2,
        S_M_NA1, S_M_NA2, S_M_B1, S_M_B2, S_M_B3, S_M_B4,
        S_UL0, S_UL1, S_UL2, S_UL3,
        S_P0, S_P1, S_P2,
        S_PL0, S_PL1, S_PL2, S_PL3, S_PL4,
        S_PS1, S_PS2, S_PS3, S_PS4, S_PS5, S_PS6,
        S_PN1, S_PN2, S_PN3,
        S_F_CHK, S_F_HD, S_F_W2,
        S_DONE
    } t_state;

    function automatic bfa_pkg::t_word f_init(input logic [WA-1:0] idx);
        bfa_pkg::t_word w;
        w = '0;
        if (idx == IDX_PRO) begin
            w = PRO_WORD;
        end else if (idx == IDX_HDR || idx == IDX_FTR) begin
            w = CHK_WORD;
        end else if (idx == IDX_EPI) begin
            w = EPI_WORD;
        end
        return w;
    endfunction

    function automatic bfa_pkg::t_word f_pack(input logic [AW-1:0] s, input logic a,
                                              input logic pa);
        return bfa_pkg::pack(32'(s), a, pa);
    endfunction

    function automatic bfa_pkg::t_word f_link(input logic [AW-1:0] a);
        return 32'(a);
    endfunction

    // state
    t_state                      r_state, n_state;
    logic [WA-1:0]               r_clr, n_clr;
    logic [AW-1:0]               r_brk, n_brk;
    logic [AW-1:0]               r_head, n_head;
    logic [bfa_pkg::CHUNK_W-1:0] r_chunk, n_chunk;
    logic                        r_ovalid, n_ovalid;
    logic [15:0]                 r_res, n_res;
    logic                        r_ok, n_ok;
    logic                        r_rd_oob, n_rd_oob;
    // working registers of one item
    logic [15:0]                 r_dres, n_dres;
    logic                        r_dok, n_dok;
    logic                        r_alloc, n_alloc;
    logic                        r_found, n_found;
    logic                        r_pa, n_pa;
    logic                        r_na, n_na;
    logic                        r_ul2, n_ul2;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [AW-1:0]               r_need, n_need;
    logic [AW-1:0]               r_bp, n_bp;
    logic [AW-1:0]               r_best, n_best;
    logic [AW-1:0]               r_slack, n_slack;
    logic [AW-1:0]               r_ext, n_ext;
    logic [AW-1:0]               r_sz, n_sz;
    logic [AW-1:0]               r_osz, n_osz;
    logic [AW-1:0]               r_nsz, n_nsz;
    logic [AW-1:0]               r_nx, n_nx;
    logic [AW-1:0]               r_pv, n_pv;
    logic [AW-1:0]               r_pred, n_pred;
    logic [AW-1:0]               r_succ, n_succ;
    logic [AW-1:0]               r_ul, n_ul;
    logic [AW-1:0]               r_addr, n_addr;

    // heap memory access
    logic [AW-1:0]   rd_a;
    logic            wr_en;
    logic [AW-1:0]   wr_a;
    bfa_pkg::t_word  wr_d;
    logic            mem_we;
    logic [WA-1:0]   mem_widx;
    bfa_pkg::t_word  mem_wdata;
    bfa_pkg::t_word  mem_q;
    bfa_pkg::t_word  rdat;
    logic [AW-1:0]   hs;
    logic [AW-1:0]   link;

    // request decode
    logic [17:0]     req_p;
    logic [17:0]     need18;
    logic [17:0]     chunk18;
    logic [AW-1:0]   slack_now;
    logic            cfg_wr;

    assign rdat = r_rd_oob ? '0 : mem_q;
    assign hs   = {rdat[AW-1:3], 3'b000};
    assign link = rdat[AW-1:0];

    assign req_p     = 18'(i_request_bytes) + 18'd11;
    assign need18    = (i_request_bytes <= 17'd8) ? 18'(bfa_pkg::MIN_BLOCK)
                                                  : {req_p[17:3], 3'b000};
    assign chunk18   = (18'(r_chunk) + 18'd7) & ~18'd7;
    assign slack_now = hs - r_need;

    // clearing pass owns the write port until the start image is in place
    assign mem_we    = (r_state == S_CLEAR) || (wr_en && (wr_a < HEAP_LIM));
    assign mem_widx  = (r_state == S_CLEAR) ? r_clr : wr_a[WA+1:2];
    assign mem_wdata = (r_state == S_CLEAR) ? f_init(r_clr) : wr_d;

    bfa_ram #(
        .WIDTH (bfa_pkg::WORD_W),
        .DEPTH (HEAP_WORDS)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_widx),
        .i_wdata (mem_wdata),
        .i_raddr (rd_a[WA+1:2]),
        .o_rdata (mem_q)
    );

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bfa_pkg::REG_GROW_CHUNK) ? 32'(r_chunk) : '0;

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_result_addr = r_res;
    assign o_ok          = r_ok;

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_brk    = r_brk;
        n_head   = r_head;
        n_chunk  = r_chunk;
        n_ovalid = r_ovalid && !i_ready;
        n_res    = r_res;
        n_ok     = r_ok;
        n_dres   = r_dres;
        n_dok    = r_dok;
        n_alloc  = r_alloc;
        n_found  = r_found;
        n_pa     = r_pa;
        n_na     = r_na;
        n_ul2    = r_ul2;
        n_cnt    = r_cnt;
        n_need   = r_need;
        n_bp     = r_bp;
        n_best   = r_best;
        n_slack  = r_slack;
        n_ext    = r_ext;
        n_sz     = r_sz;
        n_osz    = r_osz;
        n_nsz    = r_nsz;
        n_nx     = r_nx;
        n_pv     = r_pv;
        n_pred   = r_pred;
        n_succ   = r_succ;
        n_ul     = r_ul;
        n_addr   = r_addr;
        rd_a     = '0;
        wr_en    = 1'b0;
        wr_a     = '0;
        wr_d     = '0;

        if (cfg_wr && paddr[2] == bfa_pkg::REG_GROW_CHUNK) begin
            n_chunk = pwdata[bfa_pkg::CHUNK_W-1:0];
        end

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_cnt   = '0;
                    n_found = 1'b0;
                    n_dres  = '0;
                    if (i_mode == bfa_pkg::MODE_ALLOC) begin
                        n_alloc = 1'b1;
                        n_need  = AW'(need18);
                        n_bp    = r_head;
                        if (i_request_bytes == '0) begin
                            n_dok   = 1'b0;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_BF_CHK;
                        end
                    end else begin
                        n_alloc = 1'b0;
                        n_addr  = AW'(i_block_addr);
                        n_bp    = BASE;
                        if (i_block_addr == '0) begin
                            n_dok   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_F_CHK;
                        end
                    end
                end
            end
            // best-fit walk of the free list
            S_BF_CHK: begin
                if (r_bp == '0 || r_cnt == WALK_MAX) begin
                    n_state = S_BF_END;
                end else begin
                    rd_a    = r_bp - A4;
                    n_state = S_BF_SZ;
                end
            end
            S_BF_SZ: begin
                if (hs == r_need) begin
                    n_state = S_PL0;
                end else begin
                    if (hs > r_need && (!r_found || slack_now <= r_slack)) begin
                        n_found = 1'b1;
                        n_slack = slack_now;
                        n_best  = r_bp;
                    end
                    rd_a    = r_bp + A4;
                    n_state = S_BF_NX;
                end
            end
            S_BF_NX: begin
                n_bp    = link;
                n_cnt   = r_cnt + 1'b1;
                n_state = S_BF_CHK;
            end
            S_BF_END: begin
                if (r_found) begin
                    n_bp    = r_best;
                    n_state = S_PL0;
                end else begin
                    n_ext   = (r_need > AW'(chunk18)) ? r_need : AW'(chunk18);
                    n_state = S_G_CHK;
                end
            end
            // heap growth
            S_G_CHK: begin
                if (r_brk + r_ext > HEAP_LIM) begin
                    n_dok   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    rd_a    = r_brk - A4;
                    n_state = S_G_PA;
                end
            end
            S_G_PA: begin
                n_pa    = rdat[1];
                n_bp    = r_brk;
                n_brk   = r_brk + r_ext;
                wr_en   = 1'b1;
                wr_a    = r_brk - A4;
                wr_d    = f_pack(r_ext, 1'b0, rdat[1]);
                n_state = S_G_W1;
            end
            S_G_W1: begin
                wr_en   = 1'b1;
                wr_a    = r_bp + r_ext - A8;
                wr_d    = f_pack(r_ext, 1'b0, r_pa);
                n_state = S_G_W2;
            end
            S_G_W2: begin
                wr_en   = 1'b1;
                wr_a    = r_bp + r_ext - A4;
                wr_d    = EPI_WORD;
                n_state = S_M0;
            end
            // coalescing of the block at r_bp
            S_M0: begin
                rd_a    = r_bp - A4;
                n_state = S_M1;
            end
            S_M1: begin
                n_osz   = hs;
                n_pa    = rdat[1];
                n_nx    = r_bp + hs;
                rd_a    = r_bp + hs - A4;
                n_state = S_M2;
            end
            S_M2: begin
                n_na  = rdat[0];
                n_nsz = hs;
                if (r_pa && rdat[0]) begin
                    wr_en   = 1'b1;
                    wr_a    = r_nx - A4;
                    wr_d    = f_pack(hs, 1'b1, 1'b0);
                    n_state = S_P0;
                end else if (r_pa) begin
                    n_sz    = r_osz + hs;
                    wr_en   = 1'b1;
                    wr_a    = r_bp - A4;
                    wr_d    = f_pack(r_osz + hs, 1'b0, 1'b1);
                    n_state = S_M_PA1;
                end else begin
                    rd_a    = r_bp - A8;
                    n_state = S_M_PV;
                end
            end
            S_M_PA1: begin
                wr_en   = 1'b1;
                wr_a    = r_bp + r_sz - A8;
                wr_d    = f_pack(r_sz, 1'b0, 1'b1);
                rd_a    = r_bp + r_sz - A4;
                n_state = S_M_PA2;
            end
            S_M_PA2: begin
                wr_en   = 1'b1;
                wr_a    = r_bp + r_sz - A4;
                wr_d    = f_pack(hs, 1'b1, 1'b0);
                n_ul    = r_nx;
                n_ul2   = 1'b0;
                n_state = S_UL0;
            end
            S_M_PV: begin
                n_pv    = r_bp - hs;
                rd_a    = r_bp - hs - A4;
                n_state = S_M_PV2;
            end
            S_M_PV2: begin
                n_sz = r_osz + hs;
                if (r_na) begin
                    wr_en   = 1'b1;
                    wr_a    = r_bp + r_osz - A8;
                    wr_d    = f_pack(r_osz + hs, 1'b0, 1'b1);
                    n_state = S_M_NA1;
                end else begin
                    n_state = S_M_B1;
                end
            end
            S_M_NA1: begin
                wr_en   = 1'b1;
                wr_a    = r_pv - A4;
                wr_d    = f_pack(r_sz, 1'b0, 1'b1);
                n_state = S_M_NA2;
            end
            S_M_NA2: begin
                wr_en   = 1'b1;
                wr_a    = r_nx - A4;
                wr_d    = f_pack(r_nsz, 1'b1, 1'b0);
                n_bp    = r_pv;
                n_ul    = r_pv;
                n_ul2   = 1'b0;
                n_state = S_UL0;
            end
            S_M_B1: begin
                n_sz    = r_sz + r_nsz;
                n_state = S_M_B2;
            end
            S_M_B2: begin
                wr_en   = 1'b1;
                wr_a    = r_pv - A4;
                wr_d    = f_pack(r_sz, 1'b0, 1'b1);
                n_state = S_M_B3;
            end
            S_M_B3: begin
                wr_en   = 1'b1;
                wr_a    = r_nx + r_nsz - A8;
                wr_d    = f_pack(r_sz, 1'b0, 1'b1);
                rd_a    = r_pv + r_sz - A4;
                n_state = S_M_B4;
            end
            S_M_B4: begin
                wr_en   = 1'b1;
                wr_a    = r_pv + r_sz - A4;
                wr_d    = f_pack(hs, 1'b1, 1'b0);
                n_bp    = r_pv;
                n_ul    = r_nx;
                n_ul2   = 1'b1;
                n_state = S_UL0;
            end
            // unlink of r_ul, then the previous block when r_ul2 is set
            S_UL0: begin
                rd_a    = r_ul;
                n_state = S_UL1;
            end
            S_UL1: begin
                n_pred  = link;
                rd_a    = r_ul + A4;
                n_state = S_UL2;
            end
            S_UL2: begin
                n_succ = link;
                if (r_pred != '0) begin
                    wr_en = 1'b1;
                    wr_a  = r_pred + A4;
                    wr_d  = f_link(link);
                end else begin
                    n_head = link;
                end
                n_state = S_UL3;
            end
            S_UL3: begin
                if (r_succ != '0) begin
                    wr_en = 1'b1;
                    wr_a  = r_succ;
                    wr_d  = f_link(r_pred);
                end
                if (r_ul2) begin
                    n_ul    = r_pv;
                    n_ul2   = 1'b0;
                    n_state = S_UL0;
                end else begin
                    n_state = S_P0;
                end
            end
            // push r_bp at the list head
            S_P0: begin
                if (r_head != '0) begin
                    wr_en = 1'b1;
                    wr_a  = r_head;
                    wr_d  = f_link(r_bp);
                end
                n_state = S_P1;
            end
            S_P1: begin
                wr_en   = 1'b1;
                wr_a    = r_bp + A4;
                wr_d    = f_link(r_head);
                n_state = S_P2;
            end
            S_P2: begin
                wr_en  = 1'b1;
                wr_a   = r_bp;
                wr_d   = '0;
                n_head = r_bp;
                if (r_alloc) begin
                    n_state = S_PL0;
                end else begin
                    n_dok   = 1'b1;
                    n_state = S_DONE;
                end
            end
            // placement of the request in block r_bp
            S_PL0: begin
                rd_a    = r_bp;
                n_state = S_PL1;
            end
            S_PL1: begin
                n_pred  = link;
                rd_a    = r_bp + A4;
                n_state = S_PL2;
            end
            S_PL2: begin
                n_succ  = link;
                rd_a    = r_bp - A4;
                n_state = S_PL3;
            end
            S_PL3: begin
                n_sz    = hs;
                n_state = S_PL4;
            end
            S_PL4: begin
                wr_en = 1'b1;
                wr_a  = r_bp - A4;
                if (r_sz - r_need >= AW'(bfa_pkg::SPLIT_MIN)) begin
                    wr_d    = f_pack(r_need, 1'b1, 1'b1);
                    n_nx    = r_bp + r_need;
                    n_sz    = r_sz - r_need;
                    n_state = S_PS1;
                end else begin
                    wr_d    = f_pack(r_sz, 1'b1, 1'b1);
                    n_nx    = r_bp + r_sz;
                    rd_a    = r_bp + r_sz - A4;
                    n_state = S_PN1;
                end
            end
            S_PS1: begin
                wr_en   = 1'b1;
                wr_a    = r_nx - A4;
                wr_d    = f_pack(r_sz, 1'b0, 1'b1);
                n_state = S_PS2;
            end
            S_PS2: begin
                wr_en   = 1'b1;
                wr_a    = r_nx + r_sz - A8;
                wr_d    = f_pack(r_sz, 1'b0, 1'b1);
                n_state = S_PS3;
            end
            S_PS3: begin
                wr_en   = 1'b1;
                wr_a    = r_nx + A4;
                wr_d    = f_link(r_succ);
                n_state = S_PS4;
            end
            S_PS4: begin
                wr_en   = 1'b1;
                wr_a    = r_nx;
                wr_d    = f_link(r_pred);
                n_state = S_PS5;
            end
            S_PS5: begin
                if (r_pred != '0) begin
                    wr_en = 1'b1;
                    wr_a  = r_pred + A4;
                    wr_d  = f_link(r_nx);
                end else begin
                    n_head = r_nx;
                end
                n_state = S_PS6;
            end
            S_PS6: begin
                if (r_succ != '0) begin
                    wr_en = 1'b1;
                    wr_a  = r_succ;
                    wr_d  = f_link(r_nx);
                end
                n_dres  = r_bp[15:0];
                n_dok   = 1'b1;
                n_state = S_DONE;
            end
            S_PN1: begin
                wr_en   = 1'b1;
                wr_a    = r_nx - A4;
                wr_d    = f_pack(hs, 1'b1, 1'b1);
                n_state = S_PN2;
            end
            S_PN2: begin
                if (r_pred != '0) begin
                    wr_en = 1'b1;
                    wr_a  = r_pred + A4;
                    wr_d  = f_link(r_succ);
                end else begin
                    n_head = r_succ;
                end
                n_state = S_PN3;
            end
            S_PN3: begin
                if (r_succ != '0) begin
                    wr_en = 1'b1;
                    wr_a  = r_succ;
                    wr_d  = f_link(r_pred);
                end
                n_dres  = r_bp[15:0];
                n_dok   = 1'b1;
                n_state = S_DONE;
            end
            // liveness walk over the heap blocks for a free
            S_F_CHK: begin
                if (r_cnt == WALK_MAX || r_bp >= r_brk) begin
                    n_dok   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    rd_a    = r_bp - A4;
                    n_state = S_F_HD;
                end
            end
            S_F_HD: begin
                if (r_bp == r_addr) begin
                    if (rdat[0]) begin
                        n_sz    = hs;
                        n_pa    = rdat[1];
                        wr_en   = 1'b1;
                        wr_a    = r_bp - A4;
                        wr_d    = f_pack(hs, 1'b0, rdat[1]);
                        n_state = S_F_W2;
                    end else begin
                        n_dok   = 1'b0;
                        n_state = S_DONE;
                    end
                end else if (hs == '0) begin
                    n_dok   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_bp    = r_bp + hs;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_F_CHK;
                end
            end
            S_F_W2: begin
                wr_en   = 1'b1;
                wr_a    = r_bp + r_sz - A8;
                wr_d    = f_pack(r_sz, 1'b0, r_pa);
                n_state = S_M0;
            end
            // result into the output register once it is free
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_res    = r_dres;
                    n_ok     = r_dok;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rd_oob = !(rd_a < HEAP_LIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_brk    <= BRK_INIT;
            r_head   <= BASE;
            r_chunk  <= bfa_pkg::CHUNK_RESET;
            r_ovalid <= 1'b0;
            r_rd_oob <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_brk    <= n_brk;
            r_head   <= n_head;
            r_chunk  <= n_chunk;
            r_ovalid <= n_ovalid;
            r_rd_oob <= n_rd_oob;
        end
        r_res   <= n_res;
        r_ok    <= n_ok;
        r_dres  <= n_dres;
        r_dok   <= n_dok;
        r_alloc <= n_alloc;
        r_found <= n_found;
        r_pa    <= n_pa;
        r_na    <= n_na;
        r_ul2   <= n_ul2;
        r_cnt   <= n_cnt;
        r_need  <= n_need;
        r_bp    <= n_bp;
        r_best  <= n_best;
        r_slack <= n_slack;
        r_ext   <= n_ext;
        r_sz    <= n_sz;
        r_osz   <= n_osz;
        r_nsz   <= n_nsz;
        r_nx    <= n_nx;
        r_pv    <= n_pv;
        r_pred  <= n_pred;
        r_succ  <= n_succ;
        r_ul    <= n_ul;
        r_addr  <= n_addr;
    end

endmodule

[sv/bfa_chk.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_mode,
    input logic [16:0] i_request_bytes,
    input logic [15:0] i_block_addr,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_result_addr,
    input logic        o_ok,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // a stalled result holds
    `BFA_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_result_addr) && $stable(o_ok))
    // failed items carry address 0
    `BFA_ASSERT(a_fail_zero, i_clk, i_rst_n, o_valid && !o_ok |-> o_result_addr == '0)
    // block payloads sit on 8-byte boundaries
    `BFA_ASSERT(a_align, i_clk, i_rst_n, o_valid |-> (o_result_addr & 16'(bfa_pkg::SIZE_LOW_MASK)) == '0)
    // one item in work at a time
    `BFA_ASSERT(a_busy, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)
    // configuration port never waits
    `BFA_ASSERT_ALWAYS(a_pready, i_clk, pready)

endmodule

bind best_fit_free_list_allocator_unit bfa_chk u_bfa_chk (.*);
